FILE: src/sensor_command_line_parser_assert.svh
// Assertion macros used by the top level of the sensor command line parser.
`ifndef SENSOR_COMMAND_LINE_PARSER_ASSERT_SVH
`define SENSOR_COMMAND_LINE_PARSER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SCL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/scl_pkg.sv
// Types, constants and per-character parse functions of the sensor command line parser.
package scl_pkg;

    localparam int LINE_MAX = 64;
    localparam int CNT_W    = $clog2(LINE_MAX);
    localparam logic [9:0] MAG_CAP = 10'd1000;
    localparam logic [4:0] POS_CAP = 5'd31;

    localparam logic CFG_TEMP_MIN = 1'b0;
    localparam logic CFG_TEMP_MAX = 1'b1;

    typedef enum logic [1:0] {
        KIND_IGNORED  = 2'd0,
        KIND_TEMP     = 2'd1,
        KIND_BAD_TEMP = 2'd2,
        KIND_TIMEOUT  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_BAD    = 2'd3
    } phase_t;

    typedef struct packed {
        logic [2:0] tok;
        logic       in_tok;
        logic [4:0] pos;
        logic       a_sense;
        logic       a_fault;
        logic       a_temp;
        logic       a_timeout;
        logic       first_sense;
        logic       first_fault;
        logic       second_temp;
        logic       second_timeout;
        phase_t     phase;
        logic       neg;
        logic [9:0] mag;
        logic       num_ok;
    } parse_t;

    typedef struct packed {
        logic       valid;
        logic       line_end;
        logic [7:0] char_byte;
    } step_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
    } result_t;

    function automatic logic is_ws(logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic kw_sense_hit(logic [4:0] pos, logic [7:0] c);
        logic hit;
        case (pos)
            5'd0: hit = (c == "S");
            5'd1: hit = (c == "E");
            5'd2: hit = (c == "N");
            5'd3: hit = (c == "S");
            5'd4: hit = (c == "E");
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic kw_fault_hit(logic [4:0] pos, logic [7:0] c);
        logic hit;
        case (pos)
            5'd0: hit = (c == "F");
            5'd1: hit = (c == "A");
            5'd2: hit = (c == "U");
            5'd3: hit = (c == "L");
            5'd4: hit = (c == "T");
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic kw_temp_hit(logic [4:0] pos, logic [7:0] c);
        logic hit;
        case (pos)
            5'd0: hit = (c == "T");
            5'd1: hit = (c == "E");
            5'd2: hit = (c == "M");
            5'd3: hit = (c == "P");
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic kw_timeout_hit(logic [4:0] pos, logic [7:0] c);
        logic hit;
        case (pos)
            5'd0:  hit = (c == "S");
            5'd1:  hit = (c == "E");
            5'd2:  hit = (c == "N");
            5'd3:  hit = (c == "S");
            5'd4:  hit = (c == "O");
            5'd5:  hit = (c == "R");
            5'd6:  hit = (c == "_");
            5'd7:  hit = (c == "T");
            5'd8:  hit = (c == "I");
            5'd9:  hit = (c == "M");
            5'd10: hit = (c == "E");
            5'd11: hit = (c == "O");
            5'd12: hit = (c == "U");
            5'd13: hit = (c == "T");
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Closes the current token and latches what it matched.
    function automatic parse_t token_end(parse_t p);
        parse_t q;
        q = p;
        if (q.in_tok)
        begin
            q.in_tok = 1'b0;
            if (q.tok == 3'd1)
            begin
                q.first_sense = q.a_sense && (q.pos == 5'd5);
                q.first_fault = q.a_fault && (q.pos == 5'd5);
            end
            else if (q.tok == 3'd2)
            begin
                q.second_temp    = q.a_temp && (q.pos == 5'd4);
                q.second_timeout = q.a_timeout && (q.pos == 5'd14);
            end
            else if (q.tok == 3'd3)
            begin
                q.num_ok = (q.phase == PH_DIGITS);
            end
        end
        return q;
    endfunction

    // Adds one non-separator character to the current token.
    function automatic parse_t token_char(parse_t p, logic [7:0] c);
        parse_t      q;
        logic        digit;
        logic [3:0]  d;
        logic [13:0] m;
        q = p;
        digit = (c >= "0") && (c <= "9");
        d = c[3:0];
        if (!q.in_tok)
        begin
            q.in_tok = 1'b1;
            if (q.tok < 3'd4)
            begin
                q.tok = q.tok + 3'd1;
            end
            q.pos       = 5'd0;
            q.a_sense   = 1'b1;
            q.a_fault   = 1'b1;
            q.a_temp    = 1'b1;
            q.a_timeout = 1'b1;
            q.phase     = PH_LEAD;
            q.neg       = 1'b0;
            q.mag       = 10'd0;
        end
        m = ({4'd0, q.mag} * 14'd10) + {10'd0, d};
        if (q.tok == 3'd1)
        begin
            q.a_sense = q.a_sense && kw_sense_hit(q.pos, c);
            q.a_fault = q.a_fault && kw_fault_hit(q.pos, c);
        end
        else if (q.tok == 3'd2)
        begin
            q.a_temp    = q.a_temp && kw_temp_hit(q.pos, c);
            q.a_timeout = q.a_timeout && kw_timeout_hit(q.pos, c);
        end
        else if (q.tok == 3'd3)
        begin
            case (q.phase)
                PH_LEAD:
                begin
                    if (is_ws(c))
                    begin
                        q.phase = PH_LEAD;
                    end
                    else if ((c == "+") || (c == "-"))
                    begin
                        q.neg   = (c == "-");
                        q.phase = PH_SIGN;
                    end
                    else if (digit)
                    begin
                        q.mag   = {6'd0, d};
                        q.phase = PH_DIGITS;
                    end
                    else
                    begin
                        q.phase = PH_BAD;
                    end
                end
                PH_SIGN:
                begin
                    if (digit)
                    begin
                        q.mag   = {6'd0, d};
                        q.phase = PH_DIGITS;
                    end
                    else
                    begin
                        q.phase = PH_BAD;
                    end
                end
                PH_DIGITS:
                begin
                    if (digit)
                    begin
                        q.mag = (m > {4'd0, MAG_CAP}) ? MAG_CAP : m[9:0];
                    end
                    else
                    begin
                        q.phase = PH_BAD;
                    end
                end
                default:
                begin
                    q.phase = PH_BAD;
                end
            endcase
        end
        if (q.pos < POS_CAP)
        begin
            q.pos = q.pos + 5'd1;
        end
        return q;
    endfunction

endpackage

FILE: src/scl_line_parse.sv
// Line parse state: updates token, keyword and number state per character and classifies the line.
module scl_line_parse
    import scl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  step_t             step,
    input  logic signed [7:0] temp_min,
    input  logic signed [7:0] temp_max,
    output result_t           result
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             stopped_reg, stopped_next;
    logic             started_reg, started_next;
    parse_t           work_reg, work_next;
    parse_t           snap_reg, snap_next;

    parse_t            fin;
    logic signed [10:0] value;
    logic signed [10:0] lo;
    logic signed [10:0] hi;

    always_comb
    begin
        count_next   = count_reg;
        stopped_next = stopped_reg;
        started_next = started_reg;
        work_next    = work_reg;
        snap_next    = snap_reg;
        if (step.valid)
        begin
            if (step.line_end)
            begin
                count_next   = '0;
                stopped_next = 1'b0;
                started_next = 1'b0;
                work_next    = '0;
                snap_next    = '0;
            end
            else if (!stopped_reg && (count_reg < CNT_W'(LINE_MAX - 1)))
            begin
                count_next = count_reg + CNT_W'(1);
                if (step.char_byte == 8'h00)
                begin
                    stopped_next = 1'b1;
                end
                else if (started_reg || !is_ws(step.char_byte))
                begin
                    started_next = 1'b1;
                    if ((step.char_byte == 8'h20) || (step.char_byte == 8'h09))
                    begin
                        work_next = token_end(work_reg);
                    end
                    else
                    begin
                        work_next = token_char(work_reg, step.char_byte);
                    end
                    // The snapshot skips trailing whitespace of the line.
                    if (!is_ws(step.char_byte))
                    begin
                        snap_next = work_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            stopped_reg <= 1'b0;
            started_reg <= 1'b0;
            work_reg    <= '0;
            snap_reg    <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
            started_reg <= started_next;
            work_reg    <= work_next;
            snap_reg    <= snap_next;
        end
    end

    always_comb
    begin
        fin   = token_end(snap_reg);
        value = fin.neg ? -$signed({1'b0, fin.mag}) : $signed({1'b0, fin.mag});
        lo    = $signed({{3{temp_min[7]}}, temp_min});
        hi    = $signed({{3{temp_max[7]}}, temp_max});
        result.kind  = KIND_IGNORED;
        result.value = 8'd0;
        if ((fin.tok >= 3'd2) && fin.first_sense && fin.second_temp)
        begin
            result.kind = KIND_BAD_TEMP;
            if ((fin.tok == 3'd3) && fin.num_ok && (value >= lo) && (value <= hi))
            begin
                result.kind  = KIND_TEMP;
                result.value = value[7:0];
            end
        end
        else if ((fin.tok == 3'd2) && fin.first_fault && fin.second_timeout)
        begin
            result.kind = KIND_TIMEOUT;
        end
    end

endmodule

FILE: src/sensor_command_line_parser.sv
// Top level of the sensor command line parser: handshakes, configuration and result register.
// One character item is taken every cycle. Each item goes into an input register, the parse
// state updates from it in the next cycle, and an end-of-line item loads its classification
// into the result register at that same edge. Only an end-of-line item waiting in the input
// register while an earlier result is still held stops the input side and delays that
// update; character items keep flowing. Configuration writes are taken in every cycle.
module sensor_command_line_parser
    import scl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic       s_tlast,   // line_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] temp_value
    output logic [1:0] m_tuser,   // [1:0] line_kind
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

`include "sensor_command_line_parser_assert.svh"

    logic              in_valid_reg;
    logic              in_end_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    kind_t             out_kind_reg;
    logic [7:0]        out_temp_reg;
    logic signed [7:0] temp_min_reg;
    logic signed [7:0] temp_max_reg;

    logic    advance;
    logic    load;
    step_t   step;
    result_t result;

    assign advance   = !in_end_reg || !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign load      = in_valid_reg && in_end_reg && advance;
    assign cfg_ready = 1'b1;

    assign step.valid     = in_valid_reg && advance;
    assign step.line_end  = in_end_reg;
    assign step.char_byte = in_byte_reg;

    scl_line_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .temp_min (temp_min_reg),
        .temp_max (temp_max_reg),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_end_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            temp_min_reg  <= 8'sd15;
            temp_max_reg  <= 8'sd80;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
                in_end_reg   <= s_tvalid && s_tlast;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_TEMP_MIN: temp_min_reg <= cfg_data;
                    CFG_TEMP_MAX: temp_max_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
        if (load)
        begin
            out_kind_reg <= result.kind;
            out_temp_reg <= result.value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_temp_reg;
    assign m_tuser  = out_kind_reg;

    `SCL_ASSERT_NOW(a_temp_zero_unless_temp,
        out_valid_reg && (out_kind_reg != KIND_TEMP), out_temp_reg == 8'd0,
        "temperature field not zero for a non-temperature result")
    `SCL_ASSERT_NEXT(a_end_waits_for_result,
        in_valid_reg && in_end_reg && out_valid_reg && !m_tready,
        in_valid_reg && in_end_reg && out_valid_reg,
        "line end item left the input stage while the result was held")
    `SCL_ASSERT_NEXT(a_char_makes_no_result,
        in_valid_reg && !in_end_reg && !out_valid_reg, !out_valid_reg,
        "character item produced a result")

endmodule

FILE: sim/sensor_command_line_parser_test.sv
// Self-checking testbench for the sensor command line parser: directed and random lines.
module sensor_command_line_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import scl_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_ITEMS = 800;
    localparam int MAG_LIMIT    = 1000;
    localparam int TOKEN_POS_MAX = 31;
    localparam string TIMEOUT_WORD = {"SENSOR", "_TIMEOUT"};

    // Per-line token tracking, mirrored from the parser's behavior.
    typedef struct {
        int     tok;
        bit     in_tok;
        int     pos;
        bit     a_sense;
        bit     a_fault;
        bit     a_temp;
        bit     a_timeout;
        bit     first_sense;
        bit     first_fault;
        bit     second_temp;
        bit     second_timeout;
        phase_t phase;
        bit     neg;
        int     mag;
        bit     num_ok;
    } token_track_t;

    typedef struct {
        kind_t      kind;
        logic [7:0] value;
    } line_result_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [7:0] cfg_data;

    // Predicted state of the block.
    logic signed [7:0] range_lo;
    logic signed [7:0] range_hi;
    int                line_bytes;
    bit                line_halted;
    bit                text_seen;
    token_track_t      live_track;
    token_track_t      trimmed_track;

    line_result_t pending_results[$];

    int errors          = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int kind_seen[4]    = '{0, 0, 0, 0};
    int burst_left      = 0;
    int idle_cycles     = 0;
    int stall_cycle     = 0;
    int stall_mode      = 0;

    sensor_command_line_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic bit blank_char(logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic bit keyword_hit(string kw, int pos, logic [7:0] c);
        return (pos < kw.len()) && (kw[pos] == c);
    endfunction

    function automatic token_track_t cleared_track();
        token_track_t t;
        t.tok            = 0;
        t.in_tok         = 1'b0;
        t.pos            = 0;
        t.a_sense        = 1'b0;
        t.a_fault        = 1'b0;
        t.a_temp         = 1'b0;
        t.a_timeout      = 1'b0;
        t.first_sense    = 1'b0;
        t.first_fault    = 1'b0;
        t.second_temp    = 1'b0;
        t.second_timeout = 1'b0;
        t.phase          = PH_LEAD;
        t.neg            = 1'b0;
        t.mag            = 0;
        t.num_ok         = 1'b0;
        return t;
    endfunction

    function automatic token_track_t close_token(token_track_t t);
        if (!t.in_tok)
        begin
            return t;
        end
        t.in_tok = 1'b0;
        if (t.tok == 1)
        begin
            t.first_sense = t.a_sense && (t.pos == 5);
            t.first_fault = t.a_fault && (t.pos == 5);
        end
        else if (t.tok == 2)
        begin
            t.second_temp    = t.a_temp && (t.pos == 4);
            t.second_timeout = t.a_timeout && (t.pos == 14);
        end
        else if (t.tok == 3)
        begin
            t.num_ok = (t.phase == PH_DIGITS);
        end
        return t;
    endfunction

    function automatic token_track_t add_char(token_track_t t, logic [7:0] c);
        bit is_digit;
        int d;
        is_digit = (c >= "0") && (c <= "9");
        d = int'(c) - 48;
        if (!t.in_tok)
        begin
            t.in_tok = 1'b1;
            if (t.tok < 4)
            begin
                t.tok++;
            end
            t.pos       = 0;
            t.a_sense   = 1'b1;
            t.a_fault   = 1'b1;
            t.a_temp    = 1'b1;
            t.a_timeout = 1'b1;
            t.phase     = PH_LEAD;
            t.neg       = 1'b0;
            t.mag       = 0;
        end
        if (t.tok == 1)
        begin
            t.a_sense = t.a_sense && keyword_hit("SENSE", t.pos, c);
            t.a_fault = t.a_fault && keyword_hit("FAULT", t.pos, c);
        end
        else if (t.tok == 2)
        begin
            t.a_temp    = t.a_temp && keyword_hit("TEMP", t.pos, c);
            t.a_timeout = t.a_timeout && keyword_hit(TIMEOUT_WORD, t.pos, c);
        end
        else if (t.tok == 3)
        begin
            case (t.phase)
                PH_LEAD:
                begin
                    if (blank_char(c))
                    begin
                        t.phase = PH_LEAD;
                    end
                    else if ((c == "+") || (c == "-"))
                    begin
                        t.neg   = (c == "-");
                        t.phase = PH_SIGN;
                    end
                    else if (is_digit)
                    begin
                        t.mag   = d;
                        t.phase = PH_DIGITS;
                    end
                    else
                    begin
                        t.phase = PH_BAD;
                    end
                end
                PH_SIGN:
                begin
                    if (is_digit)
                    begin
                        t.mag   = d;
                        t.phase = PH_DIGITS;
                    end
                    else
                    begin
                        t.phase = PH_BAD;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        t.mag = (t.mag * 10 + d > MAG_LIMIT) ? MAG_LIMIT : t.mag * 10 + d;
                    end
                    else
                    begin
                        t.phase = PH_BAD;
                    end
                end
                default:
                begin
                    t.phase = PH_BAD;
                end
            endcase
        end
        if (t.pos < TOKEN_POS_MAX)
        begin
            t.pos++;
        end
        return t;
    endfunction

    function automatic void start_new_line();
        line_bytes    = 0;
        line_halted   = 1'b0;
        text_seen     = 1'b0;
        live_track    = cleared_track();
        trimmed_track = cleared_track();
    endfunction

    // Updates the predicted state with one accepted item; a line end queues its classification.
    function automatic void predict_item(logic [7:0] c, logic line_end);
        token_track_t p;
        line_result_t r;
        int           v;
        if (!line_end)
        begin
            if (line_halted || (line_bytes >= LINE_MAX - 1))
            begin
                return;
            end
            line_bytes++;
            if (c == 8'h00)
            begin
                line_halted = 1'b1;
                return;
            end
            if (!text_seen)
            begin
                if (blank_char(c))
                begin
                    return;
                end
                text_seen = 1'b1;
            end
            if ((c == 8'h20) || (c == 8'h09))
            begin
                live_track = close_token(live_track);
            end
            else
            begin
                live_track = add_char(live_track, c);
            end
            if (!blank_char(c))
            begin
                trimmed_track = live_track;
            end
            return;
        end
        p = close_token(trimmed_track);
        r.kind  = KIND_IGNORED;
        r.value = 8'd0;
        if ((p.tok >= 2) && p.first_sense && p.second_temp)
        begin
            r.kind = KIND_BAD_TEMP;
            if ((p.tok == 3) && p.num_ok)
            begin
                v = p.neg ? -p.mag : p.mag;
                if ((v >= int'(range_lo)) && (v <= int'(range_hi)))
                begin
                    r.kind  = KIND_TEMP;
                    r.value = 8'(v);
                end
            end
        end
        else if ((p.tok == 2) && p.first_fault && p.second_timeout)
        begin
            r.kind = KIND_TIMEOUT;
        end
        pending_results.push_back(r);
        start_new_line();
    endfunction

    // Result checker and receiver stall pattern.
    always @(posedge clk)
    begin : check_results
        line_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d value %0d",
                         $time, m_tuser, $signed(m_tdata));
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind)
                begin
                    $display("%0t: line_kind mismatch, expected %0d, actual %0d",
                             $time, want.kind, m_tuser);
                    errors++;
                end
                if (m_tdata !== want.value)
                begin
                    $display("%0t: temp_value mismatch, expected %0d, actual %0d",
                             $time, $signed(want.value), $signed(m_tdata));
                    errors++;
                end
                results_checked++;
                kind_seen[want.kind]++;
            end
        end
        stall_cycle++;
        if (stall_cycle % 157 == 0)
        begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_cycle % 4 == 0);
        endcase
    end

    // Ends the run when nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no activity for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, pending_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [7:0] c, input logic line_end);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            if ($urandom_range(0, 19) == 0)
            begin
                gap = 25;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= line_end;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_item(c, line_end);
        items_sent++;
        burst_left--;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_item(s[i], 1'b0);
        end
    endtask

    // The character byte of a line end item carries nothing, so it is random.
    task automatic end_line();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_line(input string s);
        send_text(s);
        end_line();
    endtask

    // Holds the input side until every queued result has come out, then lets the block settle.
    task automatic drain_results(input int settle_cycles);
        s_tvalid  <= 1'b0;
        burst_left = 0;
        do
        begin
            @(posedge clk);
        end
        while (pending_results.size() != 0);
        repeat (settle_cycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (index == CFG_TEMP_MIN)
        begin
            range_lo = data;
        end
        else
        begin
            range_hi = data;
        end
        reg_writes++;
    endtask

    task automatic write_range(input int lo, input int hi);
        drain_results(4);
        write_reg(CFG_TEMP_MIN, 8'(lo));
        write_reg(CFG_TEMP_MAX, 8'(hi));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0A;
            3: return 8'h0B;
            4: return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    function automatic string separator_run();
        string s;
        s = "";
        repeat ($urandom_range(1, 3))
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                s = {s, " "};
            end
            else
            begin
                s = {s, "\t"};
            end
        end
        return s;
    endfunction

    task automatic test_commands();
        send_line("SENSE TEMP 25");
        send_line({"FAULT ", TIMEOUT_WORD});
        send_line("SENSE TEMP 15");
        send_line("SENSE TEMP +80");
        send_line("SENSE TEMP 14");
        send_line("SENSE TEMP 81");
        send_line("SENSE TEMP");
        send_line("SENSE TEMP 20 30");
        send_line("SENSE TEMP 2a");
        send_line("SENSE TEMP -");
        send_line({"FAULT ", TIMEOUT_WORD, " X"});
        send_line("sense temp 20");
        send_line("SENSEX TEMP 20");
        send_line("FAULT SENSOR");
    endtask

    task automatic test_line_edges();
        // Empty and blank lines.
        send_line("");
        send_line($sformatf(" \t%c%c", 8'h0B, 8'h0D));
        // Huge magnitude saturates and lands out of range.
        send_line("SENSE TEMP 99999");
        // Leading and trailing whitespace around a valid command.
        send_line($sformatf("%cSENSE\tTEMP  40%c ", 8'h0C, 8'h0A));
        // A carriage return at the start of the number token is allowed.
        send_line($sformatf("SENSE TEMP %c33", 8'h0D));
        send_line($sformatf("SENSE TEMP 2%c", 8'hFF));
        // A zero byte ends the counted part of the line.
        send_text("SENSE TEMP 30");
        send_item(8'h00, 1'b0);
        send_line("0 X");
        // Only the first LINE_MAX-1 bytes count; the trailing 7 is dropped.
        send_text("SENSE TEMP");
        repeat (LINE_MAX - 13) send_item(8'h20, 1'b0);
        send_line("427");
    endtask

    task automatic test_range_limits();
        write_range(-128, 127);
        send_line("SENSE TEMP -128");
        send_line("SENSE TEMP 127");
        send_line("SENSE TEMP -129");
        send_line("SENSE TEMP 128");
        // An empty range rejects every number.
        write_range(10, 5);
        send_line("SENSE TEMP 7");
        write_range(0, 0);
        send_line("SENSE TEMP -0");
        send_line("SENSE TEMP 1");
        write_range(-128, -128);
        send_line("SENSE TEMP -128");
        write_range(127, 127);
        send_line("SENSE TEMP 127");
    endtask

    task automatic test_random_traffic();
        int    stop_at;
        int    next_cfg;
        int    pick;
        int    lo;
        int    hi;
        int    v;
        int    k;
        string s;
        string num;
        stop_at  = items_sent + RANDOM_ITEMS;
        next_cfg = items_sent;
        while (items_sent < stop_at)
        begin
            if (items_sent >= next_cfg)
            begin
                lo = int'($urandom_range(0, 255)) - 128;
                hi = int'($urandom_range(0, 255)) - 128;
                if ((lo > hi) && ($urandom_range(0, 3) != 0))
                begin
                    v  = lo;
                    lo = hi;
                    hi = v;
                end
                write_range(lo, hi);
                next_cfg = items_sent + $urandom_range(200, 320);
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                drain_results(0);
            end

            // Number token: mostly near the configured range.
            lo = int'(range_lo);
            hi = int'(range_hi);
            if (lo > hi)
            begin
                v  = lo;
                lo = hi;
                hi = v;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                v   = lo - 3 + int'($urandom_range(0, hi - lo + 6));
                num = $sformatf("%0d", v);
            end
            else if (pick < 8)
            begin
                v   = int'($urandom_range(0, 400)) - 200;
                num = $sformatf("%0d", v);
            end
            else
            begin
                num = "";
                repeat ($urandom_range(4, 8))
                begin
                    num = $sformatf("%s%0d", num, $urandom_range(0, 9));
                end
            end
            if ((num[0] != "-") && ($urandom_range(0, 4) == 0))
            begin
                num = {"+", num};
            end
            if ($urandom_range(0, 9) == 0)
            begin
                num = $sformatf("%c%s", 8'($urandom_range(10, 13)), num);
            end

            s = "";
            repeat ($urandom_range(0, 2)) s = $sformatf("%s%c", s, pick_blank());
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                s = {s, "SENSE", separator_run(), "TEMP"};
                if ($urandom_range(0, 19) != 0)
                begin
                    s = {s, separator_run(), num};
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    s = {s, separator_run(), "1"};
                end
            end
            else if (pick < 70)
            begin
                s = {s, "FAULT", separator_run(), TIMEOUT_WORD};
                if ($urandom_range(0, 6) == 0)
                begin
                    s = {s, separator_run(), "Z"};
                end
            end
            else if (pick < 75)
            begin
                s = {s, "SENSE TEMP"};
                repeat ($urandom_range(45, 58)) s = {s, " "};
                s = {s, num};
            end
            else if (pick < 95)
            begin
                // Raw noise goes straight out, zero bytes included.
                repeat ($urandom_range(0, 20)) send_item(8'($urandom_range(0, 255)), 1'b0);
                end_line();
                continue;
            end
            else
            begin
                repeat ($urandom_range(0, 4)) s = $sformatf("%s%c", s, pick_blank());
            end
            repeat ($urandom_range(0, 2)) s = $sformatf("%s%c", s, pick_blank());

            if ((s.len() > 0) && ($urandom_range(0, 9) == 0))
            begin
                s.putc($urandom_range(0, s.len() - 1), 8'($urandom_range(1, 255)));
            end
            if ((s.len() > 0) && ($urandom_range(0, 29) == 0))
            begin
                k = $urandom_range(0, s.len() - 1);
                send_text(s.substr(0, k - 1));
                send_item(8'h00, 1'b0);
                send_line(s.substr(k, s.len() - 1));
            end
            else
            begin
                send_line(s);
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TEMP_MIN;
        cfg_data  = 8'd0;
        range_lo  = 8'sd15;
        range_hi  = 8'sd80;
        start_new_line();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_commands();
        test_line_edges();
        test_range_limits();
        test_random_traffic();

        drain_results(8);
        $display("Sent %0d items and %0d register writes; checked %0d line results.",
                 items_sent, reg_writes, results_checked);
        $display("Kinds seen: ignored %0d, temperature %0d, invalid %0d, timeout %0d.",
                 kind_seen[KIND_IGNORED], kind_seen[KIND_TEMP],
                 kind_seen[KIND_BAD_TEMP], kind_seen[KIND_TIMEOUT]);
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/scl_pkg.sv
src/scl_line_parse.sv
src/sensor_command_line_parser.sv
sim/sensor_command_line_parser_test.sv
